// ----- design/dag_cycle_and_covered_edge_check_unit_macros.svh -----
// Assertion macros for the graph check unit RTL (used by dccc_ctrl.sv).
// The clocked form expects clk_i and rst_ni in the module that uses it.
`ifndef DAG_CYCLE_AND_COVERED_EDGE_CHECK_UNIT_MACROS_SVH
`define DAG_CYCLE_AND_COVERED_EDGE_CHECK_UNIT_MACROS_SVH

`ifndef SYNTH
`define DCCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dccc assertion failed");
`define DCCC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("dccc assertion failed");
`else
`define DCCC_ASSERT(lbl, prop)
`define DCCC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- design/dccc_pkg.sv -----
`default_nettype none

package dccc_pkg;

  localparam int NODES   = 16;
  localparam int NODE_W  = 4;
  localparam int CNT_W   = 5;
  localparam int CFG_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] NODES_IN_USE_RESET = CFG_W'(16);

  // Register index, taken from paddr bit 2 (one 32-bit register per word).
  localparam logic REG_NODES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    FUNC_LOAD      = 2'd0,
    FUNC_ACYC_EDGE = 2'd1,
    FUNC_ACYC      = 2'd2,
    FUNC_COVER     = 2'd3
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [NODE_W-1:0] row_index;
    logic [NODES-1:0]  row_bits;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic  answer;
    func_e answered_func;
  } out_item_t;

  typedef struct packed {
    logic load_row;
    logic take_query;
    logic start_closure;
    logic step;
    logic capture_cycle;
    logic capture_cover;
  } dp_cmd_t;

  typedef struct packed {
    logic last_pass;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/dccc_ctrl.sv -----
`default_nettype none

`include "dag_cycle_and_covered_edge_check_unit_macros.svh"

module dccc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dccc_pkg::func_e      func_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dccc_pkg::dp_cmd_t    cmd_o,
  input  dccc_pkg::dp_status_t status_i
);
  import dccc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLOSE = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_LOAD: begin
              cmd_o.load_row = 1'b1;
            end
            FUNC_ACYC_EDGE, FUNC_ACYC: begin
              cmd_o.take_query    = 1'b1;
              cmd_o.start_closure = 1'b1;
              state_d             = ST_CLOSE;
            end
            FUNC_COVER: begin
              cmd_o.take_query    = 1'b1;
              cmd_o.capture_cover = 1'b1;
              state_d             = ST_OUT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLOSE: begin
        cmd_o.step = 1'b1;
        if (status_i.last_pass) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.capture_cycle = 1'b1;
        state_d             = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // No new item may enter while a result is still pending.
  `DCCC_ASSERT(a_no_accept_with_result, out_valid_o |-> in_stall_o)
  // A query always leaves the idle state; a row load never does.
  `DCCC_ASSERT(a_query_leaves_idle,
      (accept && (func_i != FUNC_LOAD)) |=> (state_q != ST_IDLE))
  `DCCC_ASSERT(a_load_stays_idle, (accept && (func_i == FUNC_LOAD)) |=> !in_stall_o)
  // The cycle check is a single step straight into result delivery.
  `DCCC_ASSERT(a_check_then_out, (state_q == ST_CHECK) |=> out_valid_o)

endmodule

`default_nettype wire

// ----- design/dccc_datapath.sv -----
`default_nettype none

module dccc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dccc_pkg::in_item_t            in_item_i,
  input  logic [dccc_pkg::CFG_W-1:0]    nodes_in_use_i,
  input  dccc_pkg::dp_cmd_t             cmd_i,
  output dccc_pkg::dp_status_t          status_o,
  output dccc_pkg::out_item_t           out_item_o
);
  import dccc_pkg::*;

  logic [NODES-1:0] adj_q   [NODES];
  logic [NODES-1:0] reach_q [NODES];
  logic [NODES-1:0] reach_init [NODES];
  logic [NODES-1:0] reach_nx   [NODES];
  logic [CNT_W-1:0] pass_left_q;
  logic             answer_q;
  func_e            func_q;

  logic [CNT_W-1:0] n_eff;
  logic [NODES-1:0] use_mask;
  logic             from_in, to_in, add_edge;
  logic             has_cycle;
  logic [NODES-1:0] par_from, par_to, from_bit;
  logic             cover_ans;

  // Node count clamped to 1..NODES.
  always_comb begin
    if (nodes_in_use_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(nodes_in_use_i) > CNT_W'(NODES)) begin
      n_eff = CNT_W'(NODES);
    end else begin
      n_eff = CNT_W'(nodes_in_use_i);
    end
  end

  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      use_mask[j] = (CNT_W'(j) < n_eff);
    end
  end

  assign from_in  = (CNT_W'(in_item_i.from_node) < n_eff);
  assign to_in    = (CNT_W'(in_item_i.to_node) < n_eff);
  assign add_edge = (in_item_i.func == FUNC_ACYC_EDGE) && from_in && to_in;

  // Starting reach matrix: stored rows, plus the proposed edge when it applies.
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      reach_init[i] = adj_q[i];
      if (add_edge && (NODE_W'(i) == in_item_i.from_node)) begin
        reach_init[i][in_item_i.to_node] = 1'b1;
      end
      reach_init[i] = use_mask[i] ? (reach_init[i] & use_mask) : '0;
    end
  end

  // One closure pass: every row absorbs the rows of all nodes it reaches.
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      reach_nx[i] = reach_q[i];
      for (int j = 0; j < NODES; j++) begin
        if (reach_q[i][j]) begin
          reach_nx[i] = reach_nx[i] | reach_q[j];
        end
      end
    end
  end

  always_comb begin
    has_cycle = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      has_cycle = has_cycle | reach_q[i][i];
    end
  end

  // Covered edge: parents of the target equal parents of the source plus the source.
  always_comb begin
    from_bit = '0;
    from_bit[in_item_i.from_node] = 1'b1;
    for (int k = 0; k < NODES; k++) begin
      par_from[k] = adj_q[k][in_item_i.from_node] & use_mask[k];
      par_to[k]   = adj_q[k][in_item_i.to_node] & use_mask[k];
    end
  end

  assign cover_ans = from_in && to_in && (in_item_i.from_node != in_item_i.to_node) &&
                     !adj_q[in_item_i.from_node][in_item_i.from_node] &&
                     (par_to == (par_from | from_bit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        adj_q[i] <= '0;
      end
      pass_left_q <= '0;
    end else begin
      if (cmd_i.load_row) begin
        adj_q[in_item_i.row_index] <= in_item_i.row_bits;
      end
      if (cmd_i.start_closure) begin
        pass_left_q <= n_eff;
      end else if (cmd_i.step) begin
        pass_left_q <= pass_left_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_closure) begin
      reach_q <= reach_init;
    end else if (cmd_i.step) begin
      reach_q <= reach_nx;
    end
    if (cmd_i.take_query) begin
      func_q <= in_item_i.func;
    end
    if (cmd_i.capture_cycle) begin
      answer_q <= !has_cycle;
    end else if (cmd_i.capture_cover) begin
      answer_q <= cover_ans;
    end
  end

  assign status_o.last_pass        = (pass_left_q == CNT_W'(1));
  assign out_item_o.answer         = answer_q;
  assign out_item_o.answered_func  = func_q;

endmodule

`default_nettype wire

// ----- design/dag_cycle_and_covered_edge_check_unit.sv -----
`default_nettype none

// Directed-graph check unit for up to 16 nodes. Rows of the adjacency matrix are
// loaded one item at a time (bit j of row i is an edge from i to j); a load returns
// no result. An acyclicity query, with or without a proposed edge added for that
// test only, runs a reachability closure in which every row is updated in parallel
// once per cycle, for as many passes as there are nodes in use: n passes, where n
// is the node count set in register nodes_in_use (clamped to 1..16). A covered-edge
// query is answered from the stored rows into a result register. One item is worked
// on at a time; the input stalls until the result has been taken. The register at
// byte address 0 must be written only while the unit is idle.
module dag_cycle_and_covered_edge_check_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dccc_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dccc_pkg::out_item_t             out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dccc_pkg::PADDR_W-1:0]    paddr,
  input  logic [dccc_pkg::PDATA_W-1:0]    pwdata,
  output logic [dccc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import dccc_pkg::*;

  logic [CFG_W-1:0] nodes_in_use_q;
  logic             cfg_write;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NODES_IN_USE);
  assign prdata    = (paddr[2] == REG_NODES_IN_USE) ? PDATA_W'(nodes_in_use_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_in_use_q <= NODES_IN_USE_RESET;
    end else if (cfg_write) begin
      nodes_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  dccc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (in_item_i.func),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dccc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_item_i      (in_item_i),
    .nodes_in_use_i (nodes_in_use_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_item_o     (out_item_o)
  );

endmodule

`default_nettype wire

// ----- test/dag_cycle_and_covered_edge_check_unit_test.sv -----
`default_nettype none

import dccc_pkg::*;

class dag_answer_tracker;
  logic [NODES-1:0] adj_rows [NODES];
  logic [CFG_W-1:0] node_count_reg;
  out_item_t        expected_answers [$];
  int unsigned      mismatch_count;

  function new();
    for (int i = 0; i < NODES; i++) adj_rows[i] = '0;
    node_count_reg = NODES_IN_USE_RESET;
    mismatch_count = 0;
  endfunction

  function void write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    if (addr[2] == REG_NODES_IN_USE) node_count_reg = data[CFG_W-1:0];
  endfunction

  function int active_nodes();
    int n;
    n = int'(node_count_reg);
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    return n;
  endfunction

  // Full transitive closure over the first n nodes, optionally with one extra edge.
  function bit closure_is_acyclic(int n, bit add_edge, int src, int dst);
    logic [NODES-1:0] reach [NODES];
    logic [NODES-1:0] keep;
    logic [NODES-1:0] acc;
    keep = (n >= NODES) ? '1 : ((NODES'(1) << n) - NODES'(1));
    for (int i = 0; i < NODES; i++) reach[i] = (i < n) ? (adj_rows[i] & keep) : '0;
    if (add_edge) reach[src][dst] = 1'b1;
    for (int pass = 0; pass < n; pass++) begin
      for (int i = 0; i < n; i++) begin
        acc = reach[i];
        for (int j = 0; j < n; j++) begin
          if (reach[i][j]) acc |= reach[j];
        end
        reach[i] = acc;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (reach[i][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function logic [NODES-1:0] parent_set(int node, int n);
    logic [NODES-1:0] p;
    p = '0;
    for (int k = 0; k < n; k++) p[k] = adj_rows[k][node];
    return p;
  endfunction

  function void note_item(in_item_t it);
    out_item_t        exp;
    logic [NODES-1:0] pf;
    logic [NODES-1:0] pt;
    logic [NODES-1:0] fb;
    int               n;
    int               src;
    int               dst;
    n = active_nodes();
    src = int'(it.from_node);
    dst = int'(it.to_node);
    exp.answered_func = it.func;
    exp.answer = 1'b0;
    case (it.func)
      FUNC_LOAD: begin
        adj_rows[it.row_index] = it.row_bits;
        return;
      end
      FUNC_ACYC_EDGE: begin
        exp.answer = closure_is_acyclic(n, (src < n) && (dst < n), src, dst);
      end
      FUNC_ACYC: begin
        exp.answer = closure_is_acyclic(n, 1'b0, 0, 0);
      end
      default: begin
        if (src < n && dst < n && src != dst) begin
          pf = parent_set(src, n);
          pt = parent_set(dst, n);
          fb = NODES'(1) << src;
          exp.answer = ((pf & fb) == '0) && (pt == (pf | fb));
        end
      end
    endcase
    expected_answers = {expected_answers, exp};
  endfunction

  function void check_answer(out_item_t got);
    out_item_t exp;
    if (expected_answers.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("answer with nothing expected: answer %0b func %0d",
                 got.answer, got.answered_func);
      end
      return;
    end
    exp = expected_answers.pop_front();
    if (got.answer !== exp.answer || got.answered_func !== exp.answered_func) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch: expected answer %0b func %0d, got answer %0b func %0d",
                 exp.answer, exp.answered_func, got.answer, got.answered_func);
      end
    end
  endfunction

  function int pending();
    return expected_answers.size();
  endfunction
endclass

module dag_cycle_and_covered_edge_check_unit_test;

  localparam logic [PADDR_W-1:0] NODES_IN_USE_ADDR = {REG_NODES_IN_USE, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR        = {~REG_NODES_IN_USE, 2'b00};
  localparam int SETTLE_CYCLES = NODES + 8;
  localparam int HOLD_OFF_CYCLES = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_item_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dag_answer_tracker tracker;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_off_request = 1'b0;

  // Graph most recently loaded by the random part, with its node order.
  logic [NODES-1:0] graph_rows [NODES];
  int               topo_order [NODES];
  int               cover_from;
  int               cover_to;

  dag_cycle_and_covered_edge_check_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  function automatic in_item_t make_item(func_e f, int row, logic [NODES-1:0] bits,
                                         int src, int dst);
    in_item_t it;
    it.func      = f;
    it.row_index = NODE_W'(row);
    it.row_bits  = bits;
    it.from_node = NODE_W'(src);
    it.to_node   = NODE_W'(dst);
    return it;
  endfunction

  function automatic in_item_t random_item();
    return make_item(func_e'($urandom_range(0, 3)), $urandom_range(0, NODES - 1),
                     NODES'($urandom), $urandom_range(0, NODES - 1),
                     $urandom_range(0, NODES - 1));
  endfunction

  // Called right after a rising edge; leaves valid high once the item is taken.
  task automatic offer_item(input in_item_t it);
    bit taken;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      in_item_i  <= random_item();
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    tracker.note_item(it);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    bit ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.write_register(addr, data);
  endtask

  // A load gives no answer, so the unit may still be busy when the queue runs dry.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_graph(input int n);
    int a;
    int b;
    int t;
    int density;
    int load_order [NODES];
    for (a = 0; a < NODES; a++) begin
      topo_order[a] = a;
      load_order[a] = a;
      graph_rows[a] = '0;
    end
    for (a = n - 1; a > 0; a--) begin
      b = $urandom_range(0, a);
      t = topo_order[a];
      topo_order[a] = topo_order[b];
      topo_order[b] = t;
    end
    density = $urandom_range(1, 12);
    for (a = 0; a < NODES; a++) begin
      for (b = a + 1; b < NODES; b++) begin
        if ($urandom_range(0, 31) < density) graph_rows[topo_order[a]][topo_order[b]] = 1'b1;
      end
    end
    // Make one edge covered: the target gets the source's parents plus the source.
    cover_from = -1;
    cover_to = -1;
    if (n >= 2 && $urandom_range(0, 1) == 1) begin
      a = $urandom_range(0, n - 2);
      b = $urandom_range(a + 1, n - 1);
      cover_from = topo_order[a];
      cover_to = topo_order[b];
      for (t = 0; t < NODES; t++) graph_rows[t][cover_to] = graph_rows[t][cover_from];
      graph_rows[cover_from][cover_to] = 1'b1;
    end
    case ($urandom_range(0, 3))
      0: begin
        if (n >= 2) begin
          a = $urandom_range(0, n - 2);
          b = $urandom_range(a + 1, n - 1);
          graph_rows[topo_order[b]][topo_order[a]] = 1'b1;
        end
      end
      1: begin
        t = $urandom_range(0, NODES - 1);
        graph_rows[t][t] = 1'b1;
      end
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      for (t = n; t < NODES; t++) graph_rows[t] = NODES'($urandom);
    end
    for (a = NODES - 1; a > 0; a--) begin
      b = $urandom_range(0, a);
      t = load_order[a];
      load_order[a] = load_order[b];
      load_order[b] = t;
    end
    for (a = 0; a < NODES; a++) begin
      t = load_order[a];
      if (t < n || $urandom_range(0, 1) == 1) begin
        offer_item(make_item(FUNC_LOAD, t, graph_rows[t], $urandom_range(0, NODES - 1),
                             $urandom_range(0, NODES - 1)));
      end
    end
  endtask

  task automatic query_burst(input int n, input int count);
    in_item_t it;
    int       idx;
    for (int q = 0; q < count; q++) begin
      it = random_item();
      case ($urandom_range(0, 11))
        0, 1: it.func = FUNC_ACYC;
        2, 3, 4: begin
          it.func = FUNC_ACYC_EDGE;
          it.from_node = NODE_W'($urandom_range(0, n - 1));
          it.to_node = NODE_W'($urandom_range(0, n - 1));
        end
        5: it.func = FUNC_ACYC_EDGE;
        6, 7: begin
          it.func = FUNC_COVER;
          if (cover_from >= 0 && $urandom_range(0, 2) != 0) begin
            it.from_node = NODE_W'(cover_from);
            it.to_node = NODE_W'(cover_to);
          end else begin
            it.from_node = NODE_W'($urandom_range(0, n - 1));
            it.to_node = NODE_W'($urandom_range(0, n - 1));
          end
        end
        8: begin
          it.func = FUNC_COVER;
          if ($urandom_range(0, 1) == 1) it.to_node = it.from_node;
        end
        9, 10: begin
          // Flip one edge of an in-use row and keep the local copy in step.
          idx = $urandom_range(0, n - 1);
          graph_rows[idx][$urandom_range(0, NODES - 1)] ^= 1'b1;
          it.func = FUNC_LOAD;
          it.row_index = NODE_W'(idx);
          it.row_bits = graph_rows[idx];
        end
        default: ;
      endcase
      offer_item(it);
    end
  endtask

  // Receiver: random holds, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) tracker.check_answer(out_item_o);
  end

  initial begin
    #8000000;
    $display("dag_cycle_and_covered_edge_check_unit_test failed");
    $finish;
  end

  initial begin
    int node_values [9];
    int value;
    int n;
    tracker = new();
    node_values = '{16, 5, 1, 31, 0, 2, 17, 9, 16};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first with the reset node count of sixteen.
    offer_item(make_item(FUNC_ACYC, 0, '0, 0, 0));
    offer_item(make_item(FUNC_ACYC_EDGE, 0, '0, 3, 3));
    offer_item(make_item(FUNC_ACYC_EDGE, 0, '0, 0, 15));
    offer_item(make_item(FUNC_COVER, 0, '0, 0, 1));
    offer_item(make_item(FUNC_COVER, 0, '0, 5, 5));
    offer_item(make_item(FUNC_LOAD, 0, '1, 0, 0));
    offer_item(make_item(FUNC_ACYC, 0, '0, 0, 0));
    offer_item(make_item(FUNC_COVER, 0, '0, 0, 1));
    offer_item(make_item(FUNC_LOAD, 0, 16'h0002, 15, 15));
    offer_item(make_item(FUNC_COVER, 15, '1, 0, 1));
    offer_item(make_item(FUNC_LOAD, 15, 16'h0001, 0, 0));
    offer_item(make_item(FUNC_ACYC_EDGE, 0, '0, 1, 15));
    offer_item(make_item(FUNC_ACYC, 0, '0, 0, 0));
    offer_item(make_item(FUNC_LOAD, 1, 16'h8000, 0, 0));
    offer_item(make_item(FUNC_ACYC, 0, '0, 0, 0));
    offer_item(make_item(FUNC_LOAD, 15, '0, 0, 0));
    offer_item(make_item(FUNC_LOAD, 1, '0, 0, 0));
    offer_item(make_item(FUNC_LOAD, 0, '0, 0, 0));
    drain_and_settle();
    // A node count of zero acts as one node.
    write_reg(NODES_IN_USE_ADDR, '0);
    offer_item(make_item(FUNC_ACYC, 0, '0, 0, 0));
    offer_item(make_item(FUNC_ACYC_EDGE, 0, '0, 0, 0));
    offer_item(make_item(FUNC_ACYC_EDGE, 0, '0, 0, 1));
    offer_item(make_item(FUNC_COVER, 0, '0, 0, 1));

    for (int ph = 0; ph < 11; ph++) begin
      value = (ph < 9) ? node_values[ph] : $urandom_range(0, 31);
      if (ph == 9) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      drain_and_settle();
      write_reg(NODES_IN_USE_ADDR, {(PDATA_W - CFG_W)'($urandom), CFG_W'(value)});
      if ($urandom_range(0, 2) == 0) begin
        @(posedge clk_i);
        write_reg(SPARE_ADDR, PDATA_W'($urandom));
      end
      n = tracker.active_nodes();
      for (int g = 0; g < 3; g++) begin
        load_graph(n);
        if (ph == 4 && g == 1) hold_off_request = 1'b1;
        query_burst(n, $urandom_range(12, 24));
      end
    end

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("dag_cycle_and_covered_edge_check_unit_test passed");
    end else begin
      $display("dag_cycle_and_covered_edge_check_unit_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
